/* rtl/core/tcptt_pkg.sv */
// Shared types and constants for the TCP connection timer table.
package tcptt_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned StW   = 4;
  localparam int unsigned ActW  = 3;
  localparam int unsigned TmrW  = 16;
  localparam int unsigned RetW  = 8;
  localparam int unsigned RtoW  = 12;
  localparam int unsigned ShW   = 4;
  localparam int unsigned BoW   = RtoW + 8;
  localparam int unsigned CfgAW = 2;
  localparam int unsigned CfgDW = 16;

  localparam logic [OpW-1:0] OP_OPEN   = 2'd0;
  localparam logic [OpW-1:0] OP_UPDATE = 2'd1;
  localparam logic [OpW-1:0] OP_TICK   = 2'd2;

  localparam logic [StW-1:0] ST_CLOSED      = 4'd0;
  localparam logic [StW-1:0] ST_SYN_SENT    = 4'd2;
  localparam logic [StW-1:0] ST_SYN_RCVD    = 4'd3;
  localparam logic [StW-1:0] ST_ESTABLISHED = 4'd4;
  localparam logic [StW-1:0] ST_FIN_WAIT_2  = 4'd6;
  localparam logic [StW-1:0] ST_TIME_WAIT   = 4'd10;

  localparam logic [ActW-1:0] ACT_ACCEPTED   = 3'd0;
  localparam logic [ActW-1:0] ACT_SYN        = 3'd1;
  localparam logic [ActW-1:0] ACT_SYN_ACK    = 3'd2;
  localparam logic [ActW-1:0] ACT_RST_ACK    = 3'd3;
  localparam logic [ActW-1:0] ACT_RETRANSMIT = 3'd4;
  localparam logic [ActW-1:0] ACT_FREED      = 3'd5;
  localparam logic [ActW-1:0] ACT_DONE       = 3'd6;

  localparam logic [CfgAW-1:0] CFG_RTO_TICKS       = 2'd0;
  localparam logic [CfgAW-1:0] CFG_MAX_RETRIES     = 2'd1;
  localparam logic [CfgAW-1:0] CFG_SYN_MAX_RETRIES = 2'd2;
  localparam logic [CfgAW-1:0] CFG_WAIT_TIMEOUT    = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [IdxW-1:0] conn_index;
    logic [StW-1:0]  conn_state;
    logic            unacked_pending;
    logic            restart_timer;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] out_index;
    logic [ActW-1:0] action;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic [StW-1:0]  proto_state;
    logic            unacked;
    logic [TmrW-1:0] timer;
    logic [RetW-1:0] retries;
  } entry_t;

endpackage

/* rtl/core/tcptt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tcp_connection_timer_table.sv */
// Top level of the TCP connection timer table.
//
//  channel  | signals                               | timing
//  ---------+---------------------------------------+-------------------------------
//  request  | start_i, req_i, busy_o                | taken when start_i & !busy_o
//  result   | result_valid_o, result_o              | one-cycle strobe, no back-pressure
//  config   | cfg_we_i, cfg_addr_i, cfg_wdata_i     | written on any edge with cfg_we_i
//
// Open writes the entry when accepted. Update reads the entry when accepted and then
// writes it back modified in the update state. A fast tick answers done from idle.
// A slow tick reads every entry in turn, the write back of each entry overlapping the
// read of the next, and ends with a done result. Every result is registered.
// Reset clears all valid bits, the tick phase and control state; config takes defaults.
// The result side cannot stall; busy_o is high only during update and slow tick.
module tcp_connection_timer_table #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned BACKOFF_CAP = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  tcptt_pkg::req_t                     req_i,
  output logic                                result_valid_o,
  output tcptt_pkg::rsp_t                     result_o,
  input  logic                                cfg_we_i,
  input  logic [tcptt_pkg::CfgAW-1:0]         cfg_addr_i,
  input  logic [tcptt_pkg::CfgDW-1:0]         cfg_wdata_i
);

  import tcptt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = $bits(entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pend_idx_q, pend_idx_d;
  req_t               req_q, req_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic               phase_q, phase_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic [RtoW-1:0]    rto_q;
  logic [RetW-1:0]    max_ret_q;
  logic [RetW-1:0]    syn_max_q;
  logic [TmrW-1:0]    wait_to_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_wdata;
  logic [EW-1:0]      ram_rdata;
  entry_t             cur;

  logic               accept;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic               in_valid;

  logic [TmrW-1:0]    tmr_inc;
  logic [ShW-1:0]     shamt;
  logic [BoW-1:0]     bo_full;
  logic [TmrW-1:0]    bo_tmr;
  logic               is_syn;
  logic               exhausted;

  function automatic rsp_t mk_rsp(logic [IdxW-1:0] idx, logic [ActW-1:0] act, logic lst);
    rsp_t r;
    r.out_index = idx;
    r.action    = act;
    r.last      = lst;
    return r;
  endfunction

  tcptt_ram #(
    .Width (EW),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur      = entry_t'(ram_rdata);
  assign accept   = start_i && !busy_o;
  assign in_addr  = AW'(req_i.conn_index);
  assign in_range = 32'(req_i.conn_index) < ENTRIES;
  assign in_valid = in_range ? valid_q[in_addr] : 1'b0;

  assign tmr_inc   = cur.timer + TmrW'(1);
  assign shamt     = (cur.retries > RetW'(BACKOFF_CAP)) ? ShW'(BACKOFF_CAP)
                                                        : cur.retries[ShW-1:0];
  assign bo_full   = BoW'(rto_q) << shamt;
  assign bo_tmr    = (|bo_full[BoW-1:TmrW]) ? {TmrW{1'b1}} : bo_full[TmrW-1:0];
  assign is_syn    = (cur.proto_state == ST_SYN_SENT) || (cur.proto_state == ST_SYN_RCVD);
  assign exhausted = (cur.retries >= max_ret_q) || (is_syn && (cur.retries >= syn_max_q));

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    req_d       = req_q;
    valid_d     = valid_q;
    phase_d     = phase_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = in_addr;
    ram_raddr   = in_addr;
    ram_wdata   = cur;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.operation) inside
            OP_OPEN, OP_UPDATE: begin
              if (!in_range || (req_i.operation == OP_UPDATE && !in_valid)) begin
                rsp_valid_d = 1'b1;
                rsp_d       = mk_rsp(req_i.conn_index, ACT_FREED, 1'b1);
              end else if (req_i.operation == OP_OPEN) begin
                ram_we                = 1'b1;
                ram_wdata.proto_state = req_i.conn_state;
                ram_wdata.unacked     = req_i.unacked_pending;
                ram_wdata.timer       = TmrW'(rto_q);
                ram_wdata.retries     = '0;
                valid_d[in_addr]      = 1'b1;
                rsp_valid_d           = 1'b1;
                rsp_d                 = mk_rsp(req_i.conn_index, ACT_ACCEPTED, 1'b1);
              end else begin
                req_d   = req_i;
                state_d = S_UPD;
              end
            end
            OP_TICK: begin
              phase_d = ~phase_q;
              if (!phase_q) begin
                rd_cnt_d = '0;
                state_d  = S_WALK;
              end else begin
                rsp_valid_d = 1'b1;
                rsp_d       = mk_rsp('0, ACT_DONE, 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      S_UPD: begin
        ram_we                = 1'b1;
        ram_waddr             = AW'(req_q.conn_index);
        ram_wdata.proto_state = req_q.conn_state;
        ram_wdata.unacked     = req_q.unacked_pending;
        ram_wdata.timer       = req_q.restart_timer ? TmrW'(rto_q) : cur.timer;
        ram_wdata.retries     = req_q.restart_timer ? '0 : cur.retries;
        rsp_valid_d           = 1'b1;
        rsp_d                 = mk_rsp(req_q.conn_index, ACT_ACCEPTED, 1'b1);
        state_d               = S_IDLE;
      end
      S_WALK: begin
        ram_raddr = AW'(rd_cnt_q);
        if (rd_cnt_q < CW'(ENTRIES)) begin
          pend_d     = 1'b1;
          pend_idx_d = AW'(rd_cnt_q);
          rd_cnt_d   = rd_cnt_q + CW'(1);
        end else begin
          state_d = S_DONE;
        end
        if (pend_q && valid_q[pend_idx_q]) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q;
          if (cur.proto_state == ST_TIME_WAIT || cur.proto_state == ST_FIN_WAIT_2) begin
            ram_wdata.timer = tmr_inc;
            if (tmr_inc == wait_to_q) begin
              valid_d[pend_idx_q] = 1'b0;
              rsp_valid_d         = 1'b1;
              rsp_d               = mk_rsp(IdxW'(pend_idx_q), ACT_FREED, 1'b0);
            end
          end else if (cur.proto_state == ST_CLOSED) begin
            valid_d[pend_idx_q] = 1'b0;
            rsp_valid_d         = 1'b1;
            rsp_d               = mk_rsp(IdxW'(pend_idx_q), ACT_FREED, 1'b0);
          end else if (cur.unacked) begin
            if (cur.timer != '0) begin
              ram_wdata.timer = cur.timer - TmrW'(1);
            end else if (exhausted) begin
              ram_wdata.proto_state = ST_CLOSED;
              rsp_valid_d           = 1'b1;
              rsp_d                 = mk_rsp(IdxW'(pend_idx_q), ACT_RST_ACK, 1'b0);
            end else begin
              ram_wdata.timer   = bo_tmr;
              ram_wdata.retries = (&cur.retries) ? cur.retries : cur.retries + RetW'(1);
              case (cur.proto_state)
                ST_SYN_RCVD: begin
                  rsp_valid_d = 1'b1;
                  rsp_d       = mk_rsp(IdxW'(pend_idx_q), ACT_SYN_ACK, 1'b0);
                end
                ST_SYN_SENT: begin
                  rsp_valid_d = 1'b1;
                  rsp_d       = mk_rsp(IdxW'(pend_idx_q), ACT_SYN, 1'b0);
                end
                ST_ESTABLISHED: begin
                  rsp_valid_d = 1'b1;
                  rsp_d       = mk_rsp(IdxW'(pend_idx_q), ACT_RETRANSMIT, 1'b0);
                end
                default: ;
              endcase
            end
          end else if (cur.proto_state == ST_ESTABLISHED) begin
            rsp_valid_d = 1'b1;
            rsp_d       = mk_rsp(IdxW'(pend_idx_q), ACT_RETRANSMIT, 1'b0);
          end
        end
      end
      S_DONE: begin
        rsp_valid_d = 1'b1;
        rsp_d       = mk_rsp('0, ACT_DONE, 1'b1);
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      valid_q     <= '0;
      phase_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
      phase_q     <= phase_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    req_q      <= req_d;
    rsp_q      <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rto_q     <= RtoW'(3);
      max_ret_q <= RetW'(12);
      syn_max_q <= RetW'(6);
      wait_to_q <= TmrW'(120);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_RTO_TICKS:       rto_q     <= cfg_wdata_i[RtoW-1:0];
        CFG_MAX_RETRIES:     max_ret_q <= cfg_wdata_i[RetW-1:0];
        CFG_SYN_MAX_RETRIES: syn_max_q <= cfg_wdata_i[RetW-1:0];
        CFG_WAIT_TIMEOUT:    wait_to_q <= cfg_wdata_i[TmrW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

endmodule
